/* hdl/hcb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code builder package
// Beat types, leaf cell contents and controller state codes.
// ----------------------------------------------------------------------------
package hcb_pkg;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [15:0] frequency;
        logic        last_item;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_symbol;
        logic [14:0] code_bits;
        logic [3:0]  code_length;
        logic        overflow;
        logic        last_code;
    } out_t;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [15:0] frequency;
    } leaf_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_HEAPIFY,
        S_SD_START,
        S_SD_LEFT,
        S_SD_RIGHT,
        S_SD_SWAP,
        S_MERGE,
        S_TAKE1,
        S_TAKE2,
        S_JOIN,
        S_UP,
        S_WALK
    } state_t;

    typedef enum logic {
        R_HEAPIFY,
        R_TAKE
    } ret_t;

endpackage

/* hdl/hcb_leaf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code builder leaf cell
// One stage of the leaf row: holds one loaded symbol and its count.
// ----------------------------------------------------------------------------
module hcb_leaf_cell (
    input  logic          clk,
    input  logic          shift,
    input  hcb_pkg::leaf_t d,
    output hcb_pkg::leaf_t q
);

    hcb_pkg::leaf_t leaf_reg;

    // Each loaded beat enters the first cell and every cell passes its
    // contents on to its neighbour.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            leaf_reg <= d;
        end
    end

    assign q = leaf_reg;

endmodule

/* hdl/huffman_code_builder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code builder unit
// Loads symbol and count beats, builds a Huffman tree on a binary min-heap
// and emits one code beat per leaf in preorder, left child first.
// ----------------------------------------------------------------------------
// Loading takes one beat per cycle; leaves enter a row of cells, one cell
// per symbol, shifting along by one cell per loaded beat. The beat marked
// last starts the build, during which no beat is taken: a copy step, then
// heapify and N-1 merges, each sift-down step reading the left child, the
// right child and then swapping, and each sift-up step moving one level.
// The build speed is set by the single heap controller, which reads one
// heap entry and one node weight per cycle. The walk then visits each of
// the 2N-1 tree nodes in turn, holding at a leaf while the output stalls.
// Symbols beyond MAX_SYMBOLS in a run are dropped and every code of that
// run carries the overflow flag. A lone symbol gets a code of length zero.
// ----------------------------------------------------------------------------
module huffman_code_builder_unit #(
    parameter int MAX_SYMBOLS  = 16,
    parameter int MAX_CODE_LEN = 15,
    parameter int FREQ_BITS    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  hcb_pkg::in_t  item,
    output logic          code_valid,
    input  logic          code_stall,
    output hcb_pkg::out_t code
);

    localparam int NN  = 2 * MAX_SYMBOLS - 1;
    localparam int NIW = $clog2(NN);
    localparam int PIW = $clog2(MAX_SYMBOLS);
    localparam int CW  = $clog2(MAX_SYMBOLS + 1);
    localparam int EFB = (FREQ_BITS < 16) ? FREQ_BITS : 16;
    localparam int WW  = EFB + $clog2(MAX_SYMBOLS);
    localparam int PW  = MAX_SYMBOLS - 1;

    // Controller state.
    hcb_pkg::state_t state_reg, state_next;
    hcb_pkg::ret_t   ret_reg;
    logic            second_reg;

    // Run bookkeeping.
    logic [CW-1:0]  loaded_reg;
    logic           dropped_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  hi_reg;
    logic [NIW-1:0] next_reg;

    // Sift-down working registers.
    logic [PIW-1:0] pos_reg, best_reg;
    logic [WW-1:0]  wx_reg, wbest_reg;
    logic [NIW-1:0] x_reg, bn_reg;

    // Merge and sift-up working registers.
    logic [NIW-1:0] a_reg, b_reg, newn_reg;
    logic [WW-1:0]  wa_reg, wnew_reg;
    logic [PIW-1:0] up_reg;

    // Tree walk registers.
    logic [NIW-1:0] cur_reg;
    logic [PIW-1:0] dep_reg;
    logic [PW-1:0]  path_reg;
    logic [PIW-1:0] sp_reg;

    // Storage.
    logic [WW-1:0]  weight_mem [NN];
    logic [NIW-1:0] lchild_mem [NN];
    logic [NIW-1:0] rchild_mem [NN];
    logic [NIW-1:0] heap_mem   [MAX_SYMBOLS];
    logic [NIW-1:0] stk_node   [MAX_SYMBOLS];
    logic [PIW-1:0] stk_dep    [MAX_SYMBOLS];
    logic [PW-1:0]  stk_path   [MAX_SYMBOLS];

    // Output register.
    hcb_pkg::out_t  code_reg;
    logic           code_valid_reg;

    // Leaf row.
    hcb_pkg::leaf_t cell_q [MAX_SYMBOLS];
    logic           cell_shift;
    logic           accept;
    logic           out_free;
    logic           emit_now;

    assign item_stall = (state_reg != hcb_pkg::S_LOAD);
    assign accept     = item_valid && !item_stall;
    assign cell_shift = accept && (int'(loaded_reg) < MAX_SYMBOLS);
    assign out_free   = !code_valid_reg || !code_stall;
    assign code_valid = code_valid_reg;
    assign code       = code_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_SYMBOLS; g++)
        begin : g_cell
            hcb_pkg::leaf_t cell_d;
            if (g == 0)
            begin : g_first
                assign cell_d = '{symbol: item.symbol, frequency: item.frequency};
            end
            else
            begin : g_rest
                assign cell_d = cell_q[g-1];
            end
            hcb_leaf_cell u_cell (
                .clk   (clk),
                .shift (cell_shift),
                .d     (cell_d),
                .q     (cell_q[g])
            );
        end
    endgenerate

    // Shared read port: one heap entry and the weight of the node it names.
    logic [PIW-1:0] hp_addr;
    logic [NIW-1:0] hp_rd;
    logic [WW-1:0]  rd_w;
    logic [PIW+1:0] lpos, rpos;
    logic           l_ok, r_ok;
    logic [PIW-1:0] par;
    logic           leaf;
    logic           up_move;

    // Child positions carry a spare top bit so that the right child of the
    // last heap slot cannot wrap round to the root.
    assign lpos = {1'b0, pos_reg, 1'b1};
    assign rpos = lpos + (PIW+2)'(1);
    assign par  = (up_reg - PIW'(1)) >> 1;

    always_comb
    begin
        case (state_reg)
            hcb_pkg::S_SD_START: hp_addr = pos_reg;
            hcb_pkg::S_SD_LEFT:  hp_addr = lpos[PIW-1:0];
            hcb_pkg::S_SD_RIGHT: hp_addr = rpos[PIW-1:0];
            hcb_pkg::S_TAKE2:    hp_addr = PIW'(cnt_reg - CW'(1));
            hcb_pkg::S_UP:       hp_addr = par;
            default:             hp_addr = '0;
        endcase
    end

    assign hp_rd   = heap_mem[hp_addr];
    assign rd_w    = weight_mem[hp_rd];
    assign l_ok    = (int'(lpos) < int'(cnt_reg)) && (rd_w < wbest_reg);
    assign r_ok    = (int'(rpos) < int'(cnt_reg)) && (rd_w < wbest_reg);
    assign up_move = (up_reg != '0) && (wnew_reg < rd_w);
    assign leaf    = (int'(cur_reg) < int'(loaded_reg));
    assign emit_now = (state_reg == hcb_pkg::S_WALK) && leaf && out_free;

    // Code formed from the walk path, cut to the longest code length.
    hcb_pkg::out_t emit_beat;
    always_comb
    begin
        logic [PW+14:0] ext;
        int             len;
        ext = {15'b0, path_reg};
        len = int'(dep_reg);
        if (len > MAX_CODE_LEN)
        begin
            ext = ext >> (len - MAX_CODE_LEN);
            len = MAX_CODE_LEN;
        end
        emit_beat.out_symbol  = cell_q[PIW'(int'(loaded_reg) - 1 - int'(cur_reg))].symbol;
        emit_beat.code_bits   = ext[14:0];
        emit_beat.code_length = 4'(len);
        emit_beat.overflow    = dropped_reg;
        emit_beat.last_code   = (sp_reg == '0);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hcb_pkg::S_LOAD:
            begin
                if (accept && item.last_item)
                begin
                    state_next = hcb_pkg::S_INIT;
                end
            end
            hcb_pkg::S_INIT:     state_next = hcb_pkg::S_HEAPIFY;
            hcb_pkg::S_HEAPIFY:
            begin
                state_next = (hi_reg != '0) ? hcb_pkg::S_SD_START : hcb_pkg::S_MERGE;
            end
            hcb_pkg::S_SD_START: state_next = hcb_pkg::S_SD_LEFT;
            hcb_pkg::S_SD_LEFT:  state_next = hcb_pkg::S_SD_RIGHT;
            hcb_pkg::S_SD_RIGHT: state_next = hcb_pkg::S_SD_SWAP;
            hcb_pkg::S_SD_SWAP:
            begin
                if (best_reg != pos_reg)
                begin
                    state_next = hcb_pkg::S_SD_LEFT;
                end
                else if (ret_reg == hcb_pkg::R_HEAPIFY)
                begin
                    state_next = hcb_pkg::S_HEAPIFY;
                end
                else
                begin
                    state_next = second_reg ? hcb_pkg::S_JOIN : hcb_pkg::S_TAKE1;
                end
            end
            hcb_pkg::S_MERGE:
            begin
                state_next = (int'(cnt_reg) > 1) ? hcb_pkg::S_TAKE1 : hcb_pkg::S_WALK;
            end
            hcb_pkg::S_TAKE1:    state_next = hcb_pkg::S_TAKE2;
            hcb_pkg::S_TAKE2:    state_next = hcb_pkg::S_SD_START;
            hcb_pkg::S_JOIN:     state_next = hcb_pkg::S_UP;
            hcb_pkg::S_UP:
            begin
                if (!up_move)
                begin
                    state_next = hcb_pkg::S_MERGE;
                end
            end
            hcb_pkg::S_WALK:
            begin
                if (leaf && out_free && sp_reg == '0)
                begin
                    state_next = hcb_pkg::S_LOAD;
                end
            end
            default:             state_next = hcb_pkg::S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcb_pkg::S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg     <= '0;
            dropped_reg    <= 1'b0;
            cnt_reg        <= '0;
            sp_reg         <= '0;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            // A code beat stays valid until taken, and a new one is loaded
            // only when the register is free.
            code_valid_reg <= emit_now || (code_valid_reg && code_stall);
            case (state_reg)
                hcb_pkg::S_LOAD:
                begin
                    if (cell_shift)
                    begin
                        loaded_reg <= loaded_reg + CW'(1);
                    end
                    else if (accept)
                    begin
                        dropped_reg <= 1'b1;
                    end
                end
                hcb_pkg::S_INIT:  cnt_reg <= loaded_reg;
                hcb_pkg::S_MERGE:
                begin
                    if (int'(cnt_reg) <= 1)
                    begin
                        cnt_reg <= '0;
                        sp_reg  <= '0;
                    end
                end
                hcb_pkg::S_TAKE2: cnt_reg <= cnt_reg - CW'(1);
                hcb_pkg::S_JOIN:  cnt_reg <= cnt_reg + CW'(1);
                hcb_pkg::S_WALK:
                begin
                    if (leaf)
                    begin
                        if (out_free)
                        begin
                            if (sp_reg == '0)
                            begin
                                loaded_reg  <= '0;
                                dropped_reg <= 1'b0;
                            end
                            else
                            begin
                                sp_reg <= sp_reg - PIW'(1);
                            end
                        end
                    end
                    else
                    begin
                        sp_reg <= sp_reg + PIW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers and stores.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            hcb_pkg::S_INIT:
            begin
                for (int i = 0; i < MAX_SYMBOLS; i++)
                begin
                    heap_mem[i] <= NIW'(i);
                    if (i < int'(loaded_reg))
                    begin
                        weight_mem[i] <= WW'(
                            cell_q[PIW'(int'(loaded_reg) - 1 - i)].frequency[EFB-1:0]);
                    end
                end
                hi_reg   <= (int'(loaded_reg) >= 2) ?
                            CW'((int'(loaded_reg) - 2) / 2 + 1) : '0;
                next_reg <= NIW'(loaded_reg);
            end
            hcb_pkg::S_HEAPIFY:
            begin
                if (hi_reg != '0)
                begin
                    hi_reg  <= hi_reg - CW'(1);
                    pos_reg <= PIW'(hi_reg - CW'(1));
                    ret_reg <= hcb_pkg::R_HEAPIFY;
                end
            end
            hcb_pkg::S_SD_START:
            begin
                best_reg  <= pos_reg;
                wbest_reg <= rd_w;
                wx_reg    <= rd_w;
                x_reg     <= hp_rd;
            end
            hcb_pkg::S_SD_LEFT:
            begin
                if (l_ok)
                begin
                    best_reg  <= lpos[PIW-1:0];
                    wbest_reg <= rd_w;
                    bn_reg    <= hp_rd;
                end
            end
            hcb_pkg::S_SD_RIGHT:
            begin
                if (r_ok)
                begin
                    best_reg  <= rpos[PIW-1:0];
                    wbest_reg <= rd_w;
                    bn_reg    <= hp_rd;
                end
            end
            hcb_pkg::S_SD_SWAP:
            begin
                if (best_reg != pos_reg)
                begin
                    heap_mem[best_reg] <= x_reg;
                    heap_mem[pos_reg]  <= bn_reg;
                    pos_reg            <= best_reg;
                    wbest_reg          <= wx_reg;
                end
                else if (ret_reg == hcb_pkg::R_TAKE)
                begin
                    second_reg <= 1'b1;
                end
            end
            hcb_pkg::S_MERGE:
            begin
                second_reg <= 1'b0;
                ret_reg    <= hcb_pkg::R_TAKE;
                cur_reg    <= hp_rd;
                dep_reg    <= '0;
                path_reg   <= '0;
            end
            hcb_pkg::S_TAKE1:
            begin
                if (!second_reg)
                begin
                    a_reg  <= hp_rd;
                    wa_reg <= rd_w;
                end
                else
                begin
                    b_reg    <= hp_rd;
                    wnew_reg <= wa_reg + rd_w;
                end
            end
            hcb_pkg::S_TAKE2:
            begin
                heap_mem[0] <= hp_rd;
                pos_reg     <= '0;
            end
            hcb_pkg::S_JOIN:
            begin
                weight_mem[next_reg] <= wnew_reg;
                lchild_mem[next_reg] <= a_reg;
                rchild_mem[next_reg] <= b_reg;
                newn_reg             <= next_reg;
                next_reg             <= next_reg + NIW'(1);
                up_reg               <= PIW'(cnt_reg);
            end
            hcb_pkg::S_UP:
            begin
                if (up_move)
                begin
                    heap_mem[up_reg] <= hp_rd;
                    up_reg           <= par;
                end
                else
                begin
                    heap_mem[up_reg] <= newn_reg;
                end
            end
            hcb_pkg::S_WALK:
            begin
                if (leaf)
                begin
                    if (out_free)
                    begin
                        code_reg <= emit_beat;
                        if (sp_reg != '0)
                        begin
                            cur_reg  <= stk_node[sp_reg - PIW'(1)];
                            dep_reg  <= stk_dep[sp_reg - PIW'(1)];
                            path_reg <= stk_path[sp_reg - PIW'(1)];
                        end
                    end
                end
                else
                begin
                    // Park the right branch and descend to the left.
                    stk_node[sp_reg] <= rchild_mem[cur_reg];
                    stk_dep[sp_reg]  <= dep_reg + PIW'(1);
                    stk_path[sp_reg] <= {path_reg[PW-2:0], 1'b1};
                    cur_reg          <= lchild_mem[cur_reg];
                    dep_reg          <= dep_reg + PIW'(1);
                    path_reg         <= {path_reg[PW-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // The leaf count never passes the capacity of the cell row.
    a_loaded_cap: assert property (@(posedge clk) disable iff (!rst_n)
        int'(loaded_reg) <= MAX_SYMBOLS)
        else $error("leaf count beyond capacity");

    // A beat other than the last, taken with the row full, marks the run as overflowed.
    a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && int'(loaded_reg) == MAX_SYMBOLS && !item.last_item)
        |=> dropped_reg)
        else $error("dropped beat not flagged");

    // The heap never holds more nodes than it has slots.
    a_heap_cap: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) <= MAX_SYMBOLS)
        else $error("heap count beyond capacity");

    // The walk stack is empty whenever the block is loading.
    a_stack_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hcb_pkg::S_LOAD) |-> (sp_reg == '0))
        else $error("walk stack not empty while loading");
`endif

endmodule
